// ===== src/ifmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, constants and the digit table for the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned NUM_CELLS = 10;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned IDX_W     = $clog2(NUM_CELLS);
    localparam int unsigned ND_W      = $clog2(NUM_CELLS + 1);
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
    localparam int unsigned PAD_W     = 4;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [1:0] MODE_SDEC = 2'd0;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic clear;
        logic shift;
        logic dec;
    } t_cell_ctrl;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

// ===== src/ifmt_cell.sv =====
// ----------------------------------------------------------------------------
// ifmt_cell
// One digit cell of the shift-and-add-3 converter; in hex mode a plain nibble.
// ----------------------------------------------------------------------------
module ifmt_cell (
    input  logic                          i_clk,
    input  ifmt_pkg::t_cell_ctrl          i_ctrl,
    input  logic                          i_carry,
    output logic                          o_carry,
    output logic [ifmt_pkg::DIGIT_W-1:0]  o_digit
);

    logic [ifmt_pkg::DIGIT_W-1:0] r_digit;
    logic [ifmt_pkg::DIGIT_W-1:0] w_adj;

    // decimal: bump digits of 5 and up by 3 before the shift
    always_comb begin
        if (i_ctrl.dec && (r_digit >= 4'd5)) begin
            w_adj = r_digit + 4'd3;
        end else begin
            w_adj = r_digit;
        end
    end

    assign o_carry = w_adj[ifmt_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= {w_adj[ifmt_pkg::DIGIT_W-2:0], i_carry};
        end
    end

endmodule

// ===== src/integer_field_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_field_formatter_core
// Formats a 32-bit value as signed/unsigned decimal or lower-case hex text.
//
// Input stream: one transaction carries value, width and zero_fill in tdata
// and the conversion mode in tuser. The block takes one transaction at a
// time; tready is high only while it is idle.
// Output stream: one ASCII character per transaction, tlast on the final
// character of the field. 1 to 25 characters per input.
// The magnitude is shifted, one bit a cycle, into a row of ten digit cells
// (S_CONV); a planning state (S_PLAN) then finds the digit count and padding,
// and characters leave one per cycle from an output register while the
// receiver is ready. A new transaction can be accepted once the last
// character has been loaded into the output register.
// When the receiver stalls, the output register holds its character and the
// sequencer waits; nothing is lost.
// Reset (synchronous, active low) returns the block to idle and empties the
// output register.
// ----------------------------------------------------------------------------
module integer_field_formatter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] value, [39:32] width, [40] zero_fill, [47:41] zero
    input  logic [ifmt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] mode
    input  logic [ifmt_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] text_char
    output logic [ifmt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_PLAN, S_LEAD, S_PAD, S_SIGN, S_DIG
    } t_state;

    t_state                              r_state;
    logic [ifmt_pkg::VALUE_W-1:0]        r_mag;
    logic [ifmt_pkg::BIT_CNT_W-1:0]      r_bit_cnt;
    logic                                r_neg;
    logic                                r_zf;
    logic                                r_dec;
    logic [7:0]                          r_width;
    logic [ifmt_pkg::PAD_W-1:0]          r_pad;
    logic [ifmt_pkg::IDX_W-1:0]          r_idx;
    logic                                r_out_valid;
    logic [7:0]                          r_out_char;
    logic                                r_out_last;

    ifmt_pkg::t_cell_ctrl                w_ctrl;
    logic [ifmt_pkg::NUM_CELLS:0]        w_carry;
    logic [ifmt_pkg::DIGIT_W-1:0]        w_digits [ifmt_pkg::NUM_CELLS];

    logic                                w_accept;
    logic                                w_slot;
    logic                                w_emit;
    logic [ifmt_pkg::VALUE_W-1:0]        w_value;
    logic                                w_in_neg;
    logic [ifmt_pkg::ND_W-1:0]           w_nd;
    logic signed [9:0]                   w_count;
    logic                                w_pad_on;
    logic [ifmt_pkg::PAD_W-1:0]          w_pad;
    logic [7:0]                          w_fill;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot   = !r_out_valid || i_m_axis_tready;
    assign w_emit   = w_slot && ((r_state == S_LEAD) || (r_state == S_PAD)
                                 || (r_state == S_SIGN) || (r_state == S_DIG));

    assign w_value  = i_s_axis_tdata[ifmt_pkg::VALUE_W-1:0];
    assign w_in_neg = (i_s_axis_tuser == ifmt_pkg::MODE_SDEC) && w_value[ifmt_pkg::VALUE_W-1];

    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = (r_state == S_CONV);
    assign w_ctrl.dec   = r_dec;

    assign w_carry[0] = r_mag[ifmt_pkg::VALUE_W-1];

    for (genvar g = 0; g < ifmt_pkg::NUM_CELLS; g++) begin : g_cells
        ifmt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digits[g])
        );
    end

    always_comb begin
        w_nd = ifmt_pkg::ND_W'(1);
        for (int k = 0; k < ifmt_pkg::NUM_CELLS; k++) begin
            if (w_digits[k] != '0) begin
                w_nd = ifmt_pkg::ND_W'(k + 1);
            end
        end
    end

    assign w_count  = $signed({2'b00, r_width}) - $signed({6'b000000, w_nd})
                    + 10'sd1 - $signed({9'b0, r_neg});
    assign w_pad_on = (w_count >= 10'sd2) && (w_count <= 10'sd15);
    assign w_pad    = ifmt_pkg::PAD_W'(w_count - 10'sd1);
    assign w_fill   = r_zf ? ifmt_pkg::CHAR_ZERO : ifmt_pkg::CHAR_SPACE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit_cnt   <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag     <= w_in_neg ? (~w_value + 32'd1) : w_value;
                        r_neg     <= w_in_neg;
                        r_dec     <= !i_s_axis_tuser[1];
                        r_width   <= i_s_axis_tdata[39:32];
                        r_zf      <= i_s_axis_tdata[40];
                        r_bit_cnt <= '0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag     <= {r_mag[ifmt_pkg::VALUE_W-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == '1) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_idx <= ifmt_pkg::IDX_W'(w_nd - 1'b1);
                    r_pad <= w_pad_on ? w_pad : '0;
                    if (r_neg && r_zf) begin
                        r_state <= S_LEAD;
                    end else if (w_pad_on) begin
                        r_state <= S_PAD;
                    end else if (r_neg) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_state <= S_DIG;
                    end
                end
                S_LEAD: begin
                    if (w_slot) begin
                        r_out_char  <= ifmt_pkg::CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= (r_pad != '0) ? S_PAD : S_DIG;
                    end
                end
                S_PAD: begin
                    if (w_slot) begin
                        r_out_char  <= w_fill;
                        r_out_last  <= 1'b0;
                        r_pad       <= r_pad - 1'b1;
                        if (r_pad == ifmt_pkg::PAD_W'(1)) begin
                            r_state <= (r_neg && !r_zf) ? S_SIGN : S_DIG;
                        end
                    end
                end
                S_SIGN: begin
                    if (w_slot) begin
                        r_out_char  <= ifmt_pkg::CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (w_slot) begin
                        r_out_char  <= ifmt_pkg::digit_char(w_digits[r_idx]);
                        r_out_last  <= (r_idx == '0);
                        r_idx       <= r_idx - 1'b1;
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for integer_field_formatter_core.
//
// A driver offers formatting requests from a queue and predicts each field's
// characters when the request is accepted. A monitor checks each output
// transaction against the oldest predicted character. The stimulus runs in
// this order: directed corner cases, then random requests. The random
// requests include at least one drain pause, one stretch with no idling and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] MODE_UDEC     = 2'd1;
    localparam logic [1:0] MODE_HEX      = 2'd2;
    localparam logic [1:0] MODE_HEX_ALT  = 2'd3;
    localparam int         N_RANDOM      = 240;
    localparam int         RX_HOLD_LEN   = 300;
    localparam int         DRAIN_CYCLES  = 80;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  mode;
        logic [7:0]  width;
        logic        zero_fill;
        bit          wait_drain;
        bit          no_gap;
    } t_fmt_req;

    typedef struct {
        logic [7:0] text_char;
        logic       last;
    } t_fmt_char;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ifmt_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [ifmt_pkg::S_TUSER_W-1:0]   s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ifmt_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;

    t_fmt_req  pending_reqs[$];
    t_fmt_char expected_chars[$];
    t_fmt_req  req_on_bus;
    int        send_gap = 0;
    int        fields_sent = 0;
    int        fields_done = 0;
    int        rx_gap = 0;
    int        rx_stretch = 0;
    bit        rx_quiet = 1'b0;
    int        rx_hold_cnt = 0;
    int        failures = 0;

    integer_field_formatter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return (d < 4'd10) ? ifmt_pkg::CHAR_ZERO + 8'(d) : 8'h57 + 8'(d);
    endfunction

    // Push the characters one request must produce onto expected_chars.
    function automatic void format_field(input t_fmt_req r);
        logic [31:0] mag;
        logic [31:0] count;
        logic [7:0]  digs[12];
        logic [7:0]  text[$];
        logic [7:0]  fill;
        int unsigned nd;
        bit          hex;
        bit          neg;
        hex  = r.mode[1];
        neg  = (r.mode == ifmt_pkg::MODE_SDEC) && r.value[31];
        mag  = neg ? 32'(0) - r.value : r.value;
        fill = r.zero_fill ? ifmt_pkg::CHAR_ZERO : ifmt_pkg::CHAR_SPACE;
        nd   = 0;
        do begin
            if (hex) begin
                digs[nd] = to_ascii(mag[3:0]);
                mag = mag >> 4;
            end else begin
                digs[nd] = to_ascii(4'(mag % 32'd10));
                mag = mag / 32'd10;
            end
            nd++;
        end while (mag != 0 && nd < 12);
        count = 32'(r.width) - 32'(nd - 1) - (neg ? 32'd1 : 32'd0);
        if (neg && r.zero_fill) begin
            text.push_back(ifmt_pkg::CHAR_MINUS);
            neg = 1'b0;
        end
        if (count > 1 && count < 16) begin
            for (int i = 1; i < int'(count); i++) text.push_back(fill);
        end
        if (neg) text.push_back(ifmt_pkg::CHAR_MINUS);
        for (int i = int'(nd) - 1; i >= 0; i--) text.push_back(digs[i]);
        foreach (text[i]) begin
            expected_chars.push_back('{text_char: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] corners[10];
        corners = '{32'h0, 32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                    32'd999999999, 32'd1000000000, 32'h0fff_ffff, 32'h1000_0000,
                    32'h8000_0001};
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 99);
            1:       return 32'(0) - 32'($urandom_range(1, 1000));
            2:       return corners[$urandom_range(0, 9)];
            3:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [31:0] value, input logic [1:0] mode,
                           input logic [7:0] width, input logic zero_fill);
        pending_reqs.push_back('{value, mode, width, zero_fill, 1'b0, 1'b0});
    endtask

    // Driver
    always @(posedge i_clk) begin : driver
        bit taken;
        taken = s_tvalid && s_tready;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end else begin
            if (taken) begin
                format_field(req_on_bus);
                fields_sent++;
            end
            if (s_tvalid && !taken) begin
                // hold the offered transaction
            end else if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].wait_drain && fields_sent != fields_done)) begin
                s_tvalid <= 1'b0;
            end else begin
                req_on_bus = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, req_on_bus.zero_fill, req_on_bus.width, req_on_bus.value};
                s_tuser  <= req_on_bus.mode;
                send_gap <= req_on_bus.no_gap ? 0 : pick_gap();
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready    <= 1'b0;
            rx_gap      <= 0;
            rx_stretch  <= 0;
            rx_quiet    <= 1'b0;
            rx_hold_cnt <= 0;
        end else begin
            if (rx_stretch == 0) begin
                rx_stretch <= $urandom_range(50, 300);
                rx_quiet   <= ($urandom_range(0, 2) == 0);
            end else begin
                rx_stretch <= rx_stretch - 1;
            end
            if (fields_done >= 40 && rx_hold_cnt < RX_HOLD_LEN) begin
                m_tready    <= 1'b0;
                rx_hold_cnt <= rx_hold_cnt + 1;
            end else if (rx_gap != 0) begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end else begin
                m_tready <= 1'b1;
                rx_gap   <= rx_quiet ? 0 : pick_gap();
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin : monitor
        t_fmt_char exp_c;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (m_tlast) fields_done <= fields_done + 1;
            if (expected_chars.size() == 0) begin
                $error("unexpected transaction: text_char=%h last=%b", m_tdata, m_tlast);
                failures++;
            end else begin
                exp_c = expected_chars.pop_front();
                if (m_tdata !== exp_c.text_char) begin
                    $error("text_char mismatch: expected %h actual %h",
                           exp_c.text_char, m_tdata);
                    failures++;
                end
                if (m_tlast !== exp_c.last) begin
                    $error("last mismatch: expected %b actual %b", exp_c.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_fmt_req r;
        // directed corners
        add_req(32'h0000_0000, ifmt_pkg::MODE_SDEC, 8'd0,   1'b0);
        add_req(32'h0000_0000, MODE_HEX,            8'd5,   1'b1);
        add_req(32'h8000_0000, ifmt_pkg::MODE_SDEC, 8'd0,   1'b0);
        add_req(32'h8000_0000, ifmt_pkg::MODE_SDEC, 8'd25,  1'b0);
        add_req(32'h8000_0000, ifmt_pkg::MODE_SDEC, 8'd25,  1'b1);
        add_req(32'h8000_0000, ifmt_pkg::MODE_SDEC, 8'd14,  1'b1);
        add_req(32'h8000_0000, MODE_UDEC,           8'd12,  1'b0);
        add_req(32'hffff_ffff, ifmt_pkg::MODE_SDEC, 8'd3,   1'b0);
        add_req(32'hffff_ffff, ifmt_pkg::MODE_SDEC, 8'd3,   1'b1);
        add_req(32'hffff_fffb, ifmt_pkg::MODE_SDEC, 8'd0,   1'b1);
        add_req(32'hffff_ffff, MODE_UDEC,           8'd255, 1'b1);
        add_req(32'hffff_ffff, MODE_HEX,            8'd12,  1'b1);
        add_req(32'hdead_beef, MODE_HEX_ALT,        8'd10,  1'b0);
        add_req(32'h7fff_ffff, ifmt_pkg::MODE_SDEC, 8'd15,  1'b0);
        add_req(32'h0000_0007, MODE_UDEC,           8'd15,  1'b1);
        add_req(32'h0000_0007, MODE_UDEC,           8'd16,  1'b1);
        add_req(32'h0000_0005, ifmt_pkg::MODE_SDEC, 8'd1,   1'b0);
        add_req(32'h0000_0005, ifmt_pkg::MODE_SDEC, 8'd2,   1'b0);
        add_req(32'd123456789, MODE_HEX,            8'd8,   1'b1);
        add_req(32'h5555_5555, MODE_HEX_ALT,        8'haa,  1'b1);
        add_req(32'haaaa_aaaa, MODE_UDEC,           8'h55,  1'b0);
        for (int i = 0; i < N_RANDOM; i++) begin
            r.value      = pick_value();
            r.mode       = 2'($urandom_range(0, 3));
            r.width      = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 26))
                                                       : 8'($urandom_range(0, 255));
            r.zero_fill  = 1'($urandom_range(0, 1));
            r.wait_drain = (i == N_RANDOM / 2) || ($urandom_range(0, 49) == 0);
            r.no_gap     = (i >= 180 && i < 230);
            pending_reqs.push_back(r);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_tvalid || fields_done != fields_sent);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
        end
        if (failures == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
